[rtl/jsesc_pkg.sv]
// ---------------------------------------------------------------------------
// jsesc_pkg
// Shared types, constants and decode helpers for the escape decoder.
// ---------------------------------------------------------------------------
package jsesc_pkg;

  // Escape scanner modes
  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_BSLASH,
    MODE_HEX,
    MODE_UNI,
    MODE_OCT
  } mode_t;

  // Held escape bytes and result burst limits
  localparam int HELD_DEPTH = 5;
  localparam int RES_MAX    = 6;

  // Held byte count at which the next digit completes an escape
  localparam logic [2:0] HEX_LAST = 3'd3;
  localparam logic [2:0] UNI_LAST = 3'd5;
  localparam logic [2:0] OCT_LAST = 3'd3;

  // Request queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;

  // UTF-8 range limits and lead/continuation marks
  localparam logic [15:0] UTF8_ONE_MAX = 16'h007F;
  localparam logic [15:0] UTF8_TWO_MAX = 16'h07FF;
  localparam logic [2:0]  UTF8_LEAD2   = 3'b110;
  localparam logic [3:0]  UTF8_LEAD3   = 4'b1110;
  localparam logic [1:0]  UTF8_CONT    = 2'b10;

  // One decoded burst: up to RES_MAX bytes caused by one request
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [2:0]              count;
    logic                    stream_last;
  } cmd_t;

  // Hex digit decode: bit 4 marks a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Single-character escapes: bit 8 marks a hit
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    unique case (c)
      8'h62:     r = {1'b1, 8'h08};  // b
      8'h74:     r = {1'b1, 8'h09};  // t
      8'h6E:     r = {1'b1, 8'h0A};  // n
      8'h76:     r = {1'b1, 8'h0B};  // v
      8'h66:     r = {1'b1, 8'h0C};  // f
      8'h72:     r = {1'b1, 8'h0D};  // r
      CH_DQUOTE: r = {1'b1, c};
      CH_SQUOTE: r = {1'b1, c};
      CH_BSLASH: r = {1'b1, c};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  // Octal digit check: '0' to '7'
  function automatic logic is_octal(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

endpackage

[rtl/jsesc_front.sv]
// ---------------------------------------------------------------------------
// jsesc_front
// Scans raw bytes, tracks the open escape and builds one burst per request.
// ---------------------------------------------------------------------------
module jsesc_front import jsesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  mode_t                      mode_r, mode_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic [15:0]                val_r, val_nxt;
  logic [HELD_DEPTH-1:0][7:0] held_r, held_nxt;

  // Step results
  mode_t                      st_mode;
  logic [2:0]                 st_cnt;
  logic [15:0]                st_val;
  logic [HELD_DEPTH-1:0][7:0] st_held;
  logic [RES_MAX-1:0][7:0]    st_res;
  logic [2:0]                 st_n;

  // Decode the byte against the current mode
  always_comb begin : step_calc
    mode_t                      m;
    logic [2:0]                 cnt;
    logic [15:0]                val;
    logic [15:0]                v;
    logic [HELD_DEPTH-1:0][7:0] hb;
    logic [RES_MAX-1:0][7:0]    res;
    logic [2:0]                 n;
    logic                       feed;
    logic [4:0]                 hx;
    logic [8:0]                 se;
    logic [2:0]                 last_cnt;
    logic [7:0]                 c;
    c        = in_byte;
    m        = mode_r;
    cnt      = cnt_r;
    val      = val_r;
    v        = 16'd0;
    hb       = held_r;
    res      = '0;
    n        = 3'd0;
    feed     = 1'b0;
    hx       = hex_decode(c);
    se       = simple_escape(c);
    last_cnt = (mode_r == MODE_HEX) ? HEX_LAST : UNI_LAST;
    unique case (mode_r)
      MODE_BSLASH: begin
        if (se[8]) begin
          m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
          res[n] = se[7:0]; n = n + 3'd1;
        end else if (c == CH_LO_X || c == CH_UP_X || c == CH_LO_U || c == CH_UP_U) begin
          if (cnt < 3'(HELD_DEPTH)) begin
            hb[cnt] = c; cnt = cnt + 3'd1;
          end
          m   = (c == CH_LO_X || c == CH_UP_X) ? MODE_HEX : MODE_UNI;
          val = 16'd0;
        end else if (is_octal(c)) begin
          if (cnt < 3'(HELD_DEPTH)) begin
            hb[cnt] = c; cnt = cnt + 3'd1;
          end
          m   = MODE_OCT;
          val = {13'd0, c[2:0]};
        end else begin
          m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
          res[n] = CH_BSLASH; n = n + 3'd1;
          feed = 1'b1;
        end
      end
      MODE_HEX, MODE_UNI: begin
        if (!hx[4]) begin
          // Release the held bytes raw, rescan this byte
          for (int k = 0; k < HELD_DEPTH; k++) begin
            if (3'(k) < cnt) begin
              res[n] = hb[k]; n = n + 3'd1;
            end
          end
          m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
          feed = 1'b1;
        end else begin
          val = {val[11:0], hx[3:0]};
          if (cnt >= last_cnt) begin
            v = val;
            m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
            if (mode_r == MODE_HEX || v <= UTF8_ONE_MAX) begin
              res[n] = v[7:0]; n = n + 3'd1;
            end else if (v <= UTF8_TWO_MAX) begin
              res[n] = {UTF8_LEAD2, v[10:6]}; n = n + 3'd1;
              res[n] = {UTF8_CONT, v[5:0]};   n = n + 3'd1;
            end else begin
              res[n] = {UTF8_LEAD3, v[15:12]}; n = n + 3'd1;
              res[n] = {UTF8_CONT, v[11:6]};   n = n + 3'd1;
              res[n] = {UTF8_CONT, v[5:0]};    n = n + 3'd1;
            end
          end else if (cnt < 3'(HELD_DEPTH)) begin
            hb[cnt] = c; cnt = cnt + 3'd1;
          end
        end
      end
      MODE_OCT: begin
        if (is_octal(c)) begin
          val = {val[12:0], c[2:0]};
          if (cnt >= OCT_LAST) begin
            v = val;
            m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
            res[n] = v[7:0]; n = n + 3'd1;
          end else if (cnt < 3'(HELD_DEPTH)) begin
            hb[cnt] = c; cnt = cnt + 3'd1;
          end
        end else begin
          v = val;
          m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
          res[n] = v[7:0]; n = n + 3'd1;
          feed = 1'b1;
        end
      end
      default: begin
        feed = 1'b1;
      end
    endcase

    // Plain handling of this byte
    if (feed) begin
      val = 16'd0;
      if (c == CH_BSLASH) begin
        m = MODE_BSLASH; hb[0] = c; cnt = 3'd1;
      end else begin
        m = MODE_PLAIN; cnt = 3'd0;
        res[n] = c; n = n + 3'd1;
      end
    end

    // Close any open escape at end of string
    if (in_final) begin
      if (m == MODE_OCT) begin
        res[n] = val[7:0]; n = n + 3'd1;
      end else if (m != MODE_PLAIN) begin
        for (int k = 0; k < HELD_DEPTH; k++) begin
          if (3'(k) < cnt) begin
            res[n] = hb[k]; n = n + 3'd1;
          end
        end
      end
      m = MODE_PLAIN; cnt = 3'd0; val = 16'd0;
    end

    st_mode = m;
    st_cnt  = cnt;
    st_val  = val;
    st_held = hb;
    st_res  = res;
    st_n    = n;
  end

  // Next state: advance on an accepted request, else hold
  always_comb begin
    if (accept) begin
      mode_nxt = st_mode;
      cnt_nxt  = st_cnt;
      val_nxt  = st_val;
      held_nxt = st_held;
    end else begin
      mode_nxt = mode_r;
      cnt_nxt  = cnt_r;
      val_nxt  = val_r;
      held_nxt = held_r;
    end
  end

  // Outputs: push a burst only when the request produced bytes
  always_comb begin
    cmd_valid       = accept && (st_n != 3'd0);
    cmd.bytes       = st_res;
    cmd.count       = st_n;
    cmd.stream_last = in_final;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= 3'd0;
      val_r  <= 16'd0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      val_r  <= val_nxt;
    end
  end

  // Held escape bytes
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

[rtl/jsesc_cmdq.sv]
// ---------------------------------------------------------------------------
// jsesc_cmdq
// Short queue of decoded bursts between the scanner and the serializer.
// ---------------------------------------------------------------------------
module jsesc_cmdq import jsesc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   cnt_r, cnt_nxt;

  // Status and head
  assign full       = (cnt_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store incoming bursts
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[rtl/jsesc_back.sv]
// ---------------------------------------------------------------------------
// jsesc_back
// Walks the head burst one byte per pop and marks run and stream ends.
// ---------------------------------------------------------------------------
module jsesc_back import jsesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_stream_end,
  output logic       deq
);

  logic [2:0] idx_r, idx_nxt;
  logic       take;

  // Present the current byte of the head burst
  assign empty          = !head_valid;
  assign out_byte       = head.bytes[idx_r];
  assign out_run_end    = (idx_r == head.count - 3'd1);
  assign out_stream_end = out_run_end && head.stream_last;

  // Drop the burst after its last byte is taken
  assign take = pop && head_valid;
  assign deq  = take && out_run_end;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = out_run_end ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[rtl/javascript_escape_decoder_unit.sv]
// ---------------------------------------------------------------------------
// javascript_escape_decoder_unit
// Decodes string escapes byte by byte into raw and UTF-8 output bytes.
//
//   channel  direction  handshake         payload
//   input    in         push / full       in_byte, in_final
//   result   out        pop / empty       out_byte, out_run_end, out_stream_end
//
// One request is taken per cycle while full is low; its burst, if it has any bytes,
// is written into the 4-deep burst queue and reaches the result ports once it is
// the queue head. The serializer gives one result byte per cycle while pop is held,
// and drops a burst after its last byte; full rises only when 4 bursts are waiting.
// Synchronous active-low reset returns the scanner to plain text and
// empties the queue. Either side may stall without limit.
// ---------------------------------------------------------------------------
module javascript_escape_decoder_unit import jsesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_stream_end
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic deq;

  // Take a request when the queue has room
  assign accept = push && !full;

  jsesc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_final  (in_final),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  jsesc_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cmd_valid),
    .wr_cmd     (cmd),
    .rd_en      (deq),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  jsesc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end),
    .deq            (deq)
  );

endmodule
